FILE: sv/rmsl_pkg.sv
// Shared types and constants for the read-mark sorted list unit.
// Used by rmsl_cell and read_mark_sorted_list_unit; depends on nothing else.
package rmsl_pkg;

	localparam int STAMP_W = 31;
	localparam int CMD_W   = 2;
	localparam int COUNT_W = 7;

	typedef enum logic [CMD_W-1:0] {
		CMD_QUERY   = 2'd0,
		CMD_MARK    = 2'd1,
		CMD_CLEAR   = 2'd2,
		CMD_RESTART = 2'd3
	} cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_APPLY
	} state_t;

	typedef struct packed {
		logic cap;
		logic ins;
		logic cut;
		logic rst;
	} rmsl_ctl_t;

endpackage

FILE: sv/rmsl_cell.sv
// One cell of the sorted list: holds a single entry and its valid bit.
// Compares against the incoming stamp and shifts or truncates with its left neighbor.
// Depends on rmsl_pkg.
module rmsl_cell #(
	parameter bit IS_HEAD = 1'b0
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rmsl_pkg::rmsl_ctl_t          ctl,
	input  logic [rmsl_pkg::STAMP_W-1:0] cmp_stamp,
	input  logic [rmsl_pkg::STAMP_W-1:0] wr_stamp,
	input  logic [rmsl_pkg::STAMP_W-1:0] left_entry,
	input  logic                         left_valid,
	input  logic                         left_gt,
	output logic                         gt,
	output logic                         eq,
	output logic                         lt,
	output logic [rmsl_pkg::STAMP_W-1:0] entry,
	output logic                         valid
);
	import rmsl_pkg::*;

	logic [STAMP_W-1:0] entry_q;
	logic               valid_q;
	logic               gt_s1;
	logic               eq_s1;
	logic               lt_s1;
	logic               at_pos;
	logic               below;

	assign at_pos = !gt_s1 && left_gt;
	assign below  = !gt_s1 && !left_gt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gt_s1 <= 1'b0;
			eq_s1 <= 1'b0;
			lt_s1 <= 1'b0;
		end else if (ctl.cap) begin
			gt_s1 <= valid_q && (entry_q > cmp_stamp);
			eq_s1 <= valid_q && (entry_q == cmp_stamp);
			lt_s1 <= valid_q && (entry_q < cmp_stamp);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= STAMP_W'(IS_HEAD);
			valid_q <= IS_HEAD;
		end else if (ctl.rst) begin
			entry_q <= IS_HEAD ? STAMP_W'(1) : entry_q;
			valid_q <= IS_HEAD;
		end else if (ctl.ins) begin
			if (at_pos) begin
				entry_q <= wr_stamp;
				valid_q <= 1'b1;
			end else if (below) begin
				entry_q <= left_entry;
				valid_q <= left_valid;
			end
		end else if (ctl.cut) begin
			if (at_pos) begin
				entry_q <= wr_stamp;
			end else if (below) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign gt    = gt_s1;
	assign eq    = eq_s1;
	assign lt    = lt_s1;
	assign entry = entry_q;
	assign valid = valid_q;

endmodule

FILE: sv/read_mark_sorted_list_unit.sv
// Top level of the read-mark sorted list: a row of rmsl_cell instances and its control.
// Depends on rmsl_pkg and rmsl_cell.
//
//   channel   handshake          payload
//   command   start / busy       cmd, stamp
//   result    done (one cycle)   unread, modified, entry_count
//
// For every command, all cells compare the stamp in the accept cycle,
// then shift, insert, truncate or reset in parallel in the next (a query changes
// nothing), and the result beat is on the ports in the cycle after that. busy is
// high for that one update cycle, so a new command can be taken once busy falls.
// Reset leaves a list holding the single entry 1, ready at once.
// The receiver cannot stall; each result beat is shown for exactly one cycle.
module read_mark_sorted_list_unit #(
	parameter int MAX_ENTRIES = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [rmsl_pkg::CMD_W-1:0]   cmd,
	input  logic [rmsl_pkg::STAMP_W-1:0] stamp,
	output logic                         done,
	output logic                         unread,
	output logic                         modified,
	output logic [rmsl_pkg::COUNT_W-1:0] entry_count
);
	import rmsl_pkg::*;

	localparam int POS_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

	state_t             state_q;
	state_t             state_d;
	cmd_t               cmd_q;
	logic [STAMP_W-1:0] stamp_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   count_d;
	logic               done_q;
	logic               unread_q;
	logic               modified_q;

	logic               accept;
	logic               apply;
	rmsl_ctl_t          ctl;

	logic [MAX_ENTRIES-1:0] gt_vec;
	logic [MAX_ENTRIES-1:0] eq_vec;
	logic [MAX_ENTRIES-1:0] lt_vec;
	logic [MAX_ENTRIES-1:0] valid_vec;
	logic [MAX_ENTRIES-1:0] left_gt_vec;
	logic [MAX_ENTRIES-1:0] left_valid_vec;
	logic [MAX_ENTRIES-1:0] at_pos_vec;
	logic [STAMP_W-1:0]     entry_arr [MAX_ENTRIES];
	logic [STAMP_W-1:0]     left_entry_arr [MAX_ENTRIES];

	logic               found;
	logic               is_unread;
	logic               hit;
	logic               fresh;
	logic               mod_d;
	logic [POS_W-1:0]   pos;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_APPLY;
				end
			end
			ST_APPLY: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy  = 1'b0;
		apply = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy  = 1'b0;
				apply = 1'b0;
			end
			ST_APPLY: begin
				busy  = 1'b1;
				apply = 1'b1;
			end
			default: begin
				busy  = 1'b0;
				apply = 1'b0;
			end
		endcase
	end

	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= cmd_t'(cmd);
			stamp_q <= stamp;
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (i == 0) begin
				left_gt_vec[i]    = 1'b1;
				left_valid_vec[i] = 1'b0;
				left_entry_arr[i] = stamp_q;
			end else begin
				left_gt_vec[i]    = gt_vec[i-1];
				left_valid_vec[i] = valid_vec[i-1];
				left_entry_arr[i] = entry_arr[i-1];
			end
			at_pos_vec[i] = !gt_vec[i] && left_gt_vec[i];
		end
	end

	always_comb begin
		pos = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (at_pos_vec[i]) begin
				pos = pos | POS_W'(i);
			end
		end
	end

	assign found     = |eq_vec;
	assign hit       = found || (|lt_vec);
	assign is_unread = !found && (|lt_vec);
	assign fresh     = (count_q == CNT_W'(1)) && (entry_arr[0] == STAMP_W'(1));

	assign ctl.cap = accept;
	assign ctl.ins = apply && (cmd_q == CMD_MARK) && is_unread;
	assign ctl.cut = apply && (cmd_q == CMD_CLEAR) && hit;
	assign ctl.rst = apply && (cmd_q == CMD_RESTART);

	always_comb begin
		count_d = count_q;
		mod_d   = 1'b0;
		if (ctl.rst) begin
			count_d = CNT_W'(1);
			mod_d   = !fresh;
		end else if (ctl.ins) begin
			mod_d = 1'b1;
			if (count_q < CNT_W'(MAX_ENTRIES)) begin
				count_d = count_q + CNT_W'(1);
			end
		end else if (ctl.cut) begin
			mod_d   = 1'b1;
			count_d = CNT_W'(pos) + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_W'(1);
			done_q  <= 1'b0;
		end else begin
			count_q <= count_d;
			done_q  <= apply;
		end
	end

	always_ff @(posedge clk) begin
		if (apply) begin
			unread_q   <= is_unread;
			modified_q <= mod_d;
		end
	end

	for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
		rmsl_cell #(
			.IS_HEAD (g == 0)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.cmp_stamp  (stamp),
			.wr_stamp   (stamp_q),
			.left_entry (left_entry_arr[g]),
			.left_valid (left_valid_vec[g]),
			.left_gt    (left_gt_vec[g]),
			.gt         (gt_vec[g]),
			.eq         (eq_vec[g]),
			.lt         (lt_vec[g]),
			.entry      (entry_arr[g]),
			.valid      (valid_vec[g])
		);
	end

	assign done        = done_q;
	assign unread      = unread_q;
	assign modified    = modified_q;
	assign entry_count = COUNT_W'(count_q);

	a_done_after_apply: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == ST_APPLY))
		else $error("result beat without an update cycle");

	a_count_matches_cells: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == int'(count_q))
		else $error("entry count disagrees with the valid cells");

	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		apply |-> $onehot0(eq_vec))
		else $error("stamp matched more than one entry");

	a_head_kept: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != '0 && valid_vec[0])
		else $error("list lost its head entry");

endmodule
